@@ rtl/ecp_pkg.sv @@
package ecp_pkg;

    // Q39.24 fixed-point word
    typedef logic signed [63:0] t_fx;

    typedef enum logic [2:0] {
        REG_CAL_TEMP       = 3'd0,
        REG_CAL_PRESS_LOW  = 3'd1,
        REG_CAL_PRESS_HIGH = 3'd2,
        REG_CAL_PRESS9_HUM = 3'd3,
        REG_CAL_HUM_SHAPE  = 3'd4
    } t_reg_idx;

    localparam t_fx FX_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_fx FX_MIN   = 64'sh8000_0000_0000_0000;
    localparam t_fx FX_ONE   = 64'sd1 <<< 24;
    localparam t_fx FX_5     = 64'sd5 <<< 24;
    localparam t_fx FX_6250  = 64'sd6250 <<< 24;
    localparam t_fx FX_64000 = 64'sd64000 <<< 24;
    localparam t_fx FX_76800 = 64'sd76800 <<< 24;

    localparam t_fx TC_LO = -64'sd4000;
    localparam t_fx TC_HI = 64'sd8500;
    localparam t_fx PA_LO = 64'sd30000;
    localparam t_fx PA_HI = 64'sd110000;
    localparam t_fx HF_LO = 64'sd0;
    localparam t_fx HF_HI = 64'sd102400;

    localparam int MUL_LAT = 4;
    localparam int DIV_STEPS = 88;

    // signed 16-bit coefficient as fixed point
    function automatic t_fx fx_s16(input logic [15:0] v);
        return {{24{v[15]}}, v, 24'd0};
    endfunction

    function automatic t_fx fx_sadd(input t_fx a, input t_fx b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
        return 64'(s);
    endfunction

    function automatic t_fx fx_ssub(input t_fx a, input t_fx b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) return s[64] ? FX_MIN : FX_MAX;
        return 64'(s);
    endfunction

    // round(a / 2^n), ties away from zero
    function automatic t_fx fx_rsh(input t_fx a, input int unsigned n);
        logic signed [64:0] h;
        logic signed [64:0] s;
        h = 65'sd1 <<< (n - 1);
        s = 65'(a) + h - $signed({64'd0, a[63]});
        s = s >>> n;
        return 64'(s);
    endfunction

    function automatic t_fx fx_clamp(input t_fx a, input t_fx lo, input t_fx hi);
        if (a < lo) return lo;
        if (a > hi) return hi;
        return a;
    endfunction

    function automatic logic [63:0] fx_mag(input t_fx a);
        return a[63] ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    // apply sign to a magnitude, saturate
    function automatic t_fx fx_sgn(input logic neg, input logic [63:0] m);
        if (!neg) return m[63] ? FX_MAX : $signed(m);
        if (m[63]) return FX_MIN;
        return -$signed(m);
    endfunction

endpackage

@@ rtl/ecp_dly.sv @@
module ecp_dly
    import ecp_pkg::*;
#(
    parameter int W = 64,
    parameter int N = 4
) (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [W-1:0] i_d,
    output logic [W-1:0] o_q
);

    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int i = 1; i < N; i++) r_sr[i] <= r_sr[i-1];
        end
    end

    assign o_q = r_sr[N-1];

endmodule

@@ rtl/ecp_fmul.sv @@
module ecp_fmul
    import ecp_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_fx  i_a,
    input  t_fx  i_b,
    output t_fx  o_p
);

    logic        r_neg1, r_neg2, r_neg3;
    logic [63:0] r_ma, r_mb;
    logic [63:0] r_p00, r_p01, r_p10, r_p11;
    logic [127:0] r_sum;
    t_fx         r_p;
    logic [63:0] w_mag;

    assign w_mag = (|r_sum[127:88]) ? '1 : r_sum[87:24];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // magnitudes
            r_neg1 <= i_a[63] ^ i_b[63];
            r_ma   <= fx_mag(i_a);
            r_mb   <= fx_mag(i_b);
            // 32x32 partial products
            r_neg2 <= r_neg1;
            r_p00  <= r_ma[31:0]  * r_mb[31:0];
            r_p01  <= r_ma[31:0]  * r_mb[63:32];
            r_p10  <= r_ma[63:32] * r_mb[31:0];
            r_p11  <= r_ma[63:32] * r_mb[63:32];
            // combine, add half an LSB of the result
            r_neg3 <= r_neg2;
            r_sum  <= {64'd0, r_p00} + {32'd0, r_p01, 32'd0} + {32'd0, r_p10, 32'd0}
                    + {r_p11, 64'd0} + (128'd1 << 23);
            // drop fraction, saturate, sign
            r_p    <= fx_sgn(r_neg3, w_mag);
        end
    end

    assign o_p = r_p;

endmodule

@@ rtl/ecp_fdiv.sv @@
module ecp_fdiv
    import ecp_pkg::*;
(
    input  logic i_clk,
    input  logic i_en,
    input  t_fx  i_a,
    input  t_fx  i_b,
    output t_fx  o_q
);

    logic        r_neg0;
    logic [63:0] r_ma0, r_mb0;

    logic [63:0] r_rem [DIV_STEPS];
    logic [87:0] r_nq  [DIV_STEPS];
    logic [63:0] r_dv  [DIV_STEPS];
    logic        r_ng  [DIV_STEPS];

    logic [87:0] r_qr;
    logic        r_ngr;
    t_fx         r_q;
    logic        w_up;
    logic [63:0] w_mag;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg0 <= i_a[63] ^ i_b[63];
            r_ma0  <= fx_mag(i_a);
            r_mb0  <= fx_mag(i_b);
        end
    end

    // one restoring step per stage; numerator bits shift out as quotient bits shift in
    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
        logic [63:0] w_rem_in;
        logic [87:0] w_nq_in;
        logic [63:0] w_dv_in;
        logic        w_ng_in;
        logic [64:0] w_r65;
        logic        w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = '0;
            assign w_nq_in  = {r_ma0, 24'd0};
            assign w_dv_in  = r_mb0;
            assign w_ng_in  = r_neg0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_nq_in  = r_nq[k-1];
            assign w_dv_in  = r_dv[k-1];
            assign w_ng_in  = r_ng[k-1];
        end

        assign w_r65 = {w_rem_in, w_nq_in[87]};
        assign w_ge  = w_r65 >= {1'b0, w_dv_in};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? 64'(w_r65 - {1'b0, w_dv_in}) : w_r65[63:0];
                r_nq[k]  <= {w_nq_in[86:0], w_ge};
                r_dv[k]  <= w_dv_in;
                r_ng[k]  <= w_ng_in;
            end
        end
    end

    assign w_up  = {r_rem[DIV_STEPS-1], 1'b0} >= {1'b0, r_dv[DIV_STEPS-1]};
    assign w_mag = (|r_qr[87:64]) ? '1 : r_qr[63:0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // round to nearest
            r_qr  <= r_nq[DIV_STEPS-1] + 88'(w_up);
            r_ngr <= r_ng[DIV_STEPS-1];
            r_q   <= fx_sgn(r_ngr, w_mag);
        end
    end

    assign o_q = r_q;

endmodule

@@ rtl/env_sensor_compensation.sv @@
// Throughput: one reading per cycle while the output is not stalled; the depth is set
//   by the 88-stage pressure divider (one quotient bit per stage) and the 4-stage
//   fixed-point multipliers.
// Reset (i_rst_n low, synchronous): clears the valid pipeline and all calibration
//   registers to zero; no clearing pass, the block accepts the next cycle.
module env_sensor_compensation
    import ecp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [19:0] raw_temperature, [39:20] raw_pressure, [55:40] raw_humidity
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [14:0] temperature_centi, [31:15] pressure_pa, [48:32] humidity_frac, rest zero
    output logic [55:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [63:0] i_cfg_wdata
);

    localparam int LAST = 129;

    // ---------------- calibration registers ----------------
    logic [47:0] r_cal_temp;
    logic [63:0] r_cal_pl;
    logic [63:0] r_cal_ph;
    logic [47:0] r_cal_p9h;
    logic [31:0] r_cal_hs;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal_temp <= '0;
            r_cal_pl   <= '0;
            r_cal_ph   <= '0;
            r_cal_p9h  <= '0;
            r_cal_hs   <= '0;
        end else if (i_cfg_we) begin
            // drop writes to unknown indexes; drop bits above each width
            unique case (i_cfg_idx)
                REG_CAL_TEMP:       r_cal_temp <= i_cfg_wdata[47:0];
                REG_CAL_PRESS_LOW:  r_cal_pl   <= i_cfg_wdata;
                REG_CAL_PRESS_HIGH: r_cal_ph   <= i_cfg_wdata;
                REG_CAL_PRESS9_HUM: r_cal_p9h  <= i_cfg_wdata[47:0];
                REG_CAL_HUM_SHAPE:  r_cal_hs   <= i_cfg_wdata[31:0];
                default: ;
            endcase
        end
    end

    // Coefficients in Q24, with the fixed scale factors of the formulas folded in.
    t_fx w_t1, w_t2, w_t3;
    t_fx w_p1, w_p2, w_p3, w_p4x, w_p5x2, w_p6, w_p7, w_p8, w_p9;
    t_fx w_h1, w_h2, w_h3, w_h4x, w_h5, w_h6, w_slope;

    assign w_t1   = {24'd0, r_cal_temp[15:0], 24'd0};
    assign w_t2   = fx_s16(r_cal_temp[31:16]);
    assign w_t3   = fx_s16(r_cal_temp[47:32]);
    assign w_p1   = {24'd0, r_cal_pl[15:0], 24'd0};
    assign w_p2   = fx_s16(r_cal_pl[31:16]);
    assign w_p3   = fx_s16(r_cal_pl[47:32]);
    assign w_p4x  = {{8{r_cal_pl[63]}}, r_cal_pl[63:48], 40'd0};     // P4 * 65536
    assign w_p5x2 = {{23{r_cal_ph[15]}}, r_cal_ph[15:0], 25'd0};     // P5 * 2
    assign w_p6   = fx_s16(r_cal_ph[31:16]);
    assign w_p7   = fx_s16(r_cal_ph[47:32]);
    assign w_p8   = fx_s16(r_cal_ph[63:48]);
    assign w_p9   = fx_s16(r_cal_p9h[15:0]);
    assign w_h1   = {32'd0, r_cal_p9h[23:16], 24'd0};
    assign w_h2   = fx_s16(r_cal_p9h[39:24]);
    assign w_h3   = {32'd0, r_cal_p9h[47:40], 24'd0};
    assign w_h4x  = {22'd0, r_cal_hs[11:0], 30'd0};                  // H4 * 64
    assign w_h5   = {28'd0, r_cal_hs[23:12], 24'd0};
    assign w_h6   = {{32{r_cal_hs[31]}}, r_cal_hs[31:24], 24'd0};
    assign w_slope = fx_rsh(w_h2, 16);

    // ---------------- flow control ----------------
    // The whole pipeline advances together; hold everything while the output
    // register is full and not taken.
    logic          w_en;
    logic [LAST:0] r_vld;

    assign w_en          = !r_vld[LAST] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], s_axis_tvalid};
        end
    end

    // stage 0: capture request
    logic [19:0] r_rt, r_rp;
    logic [15:0] r_rh;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rt <= s_axis_tdata[19:0];
            r_rp <= s_axis_tdata[39:20];
            r_rh <= s_axis_tdata[55:40];
        end
    end

    // Stage numbers below name the pipeline stage, counted from capture, in which a value is held.

    // ---------------- temperature and fine term ----------------
    t_fx w_raw;
    t_fx r_lin0, r_sq0, r_fine;
    t_fx w_lin5, w_sqq5, w_sq9, w_lin9, w_tc14;
    logic [14:0] r_tc, w_tc128;

    assign w_raw = {20'd0, r_rt, 24'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_lin0 <= fx_ssub(fx_rsh(w_raw, 14), fx_rsh(w_t1, 10));      // 1
            r_sq0  <= fx_ssub(fx_rsh(w_raw, 17), fx_rsh(w_t1, 13));      // 1
            r_fine <= fx_sadd(w_lin9, w_sq9);                            // 10
            r_tc   <= 15'(fx_clamp(fx_rsh(w_tc14, 32), TC_LO, TC_HI));  // 15
        end
    end

    ecp_fmul u_m_lin (.i_clk, .i_en(w_en), .i_a(r_lin0), .i_b(w_t2), .o_p(w_lin5));
    ecp_fmul u_m_sqq (.i_clk, .i_en(w_en), .i_a(r_sq0),  .i_b(r_sq0), .o_p(w_sqq5));
    ecp_fmul u_m_sq  (.i_clk, .i_en(w_en), .i_a(w_sqq5), .i_b(w_t3), .o_p(w_sq9));
    ecp_dly #(.W(64), .N(4)) u_d_lin (.i_clk, .i_en(w_en), .i_d(w_lin5), .o_q(w_lin9));
    ecp_fmul u_m_tc  (.i_clk, .i_en(w_en), .i_a(r_fine), .i_b(FX_5), .o_p(w_tc14));
    ecp_dly #(.W(15), .N(113)) u_d_tc (.i_clk, .i_en(w_en), .i_d(r_tc), .o_q(w_tc128));

    // ---------------- pressure ----------------
    t_fx r_x0, r_y2, r_zs, r_y3, r_x1, r_den0, r_pr0, r_s1, r_s2, r_pr2;
    t_fx w_xx15, w_x5_15, w_p3_15, w_p2_15, w_x0_15;
    t_fx w_y6_19, w_z19, w_x5_19, w_p2_19;
    t_fx w_den26, w_num26, w_pr117, w_pr121, w_pr127;
    t_fx w_e9a121, w_e8_121, w_e9_125, w_e8_125, w_rpx;
    logic [19:0] w_rp21;
    logic [20:0] w_rpd;
    logic        r_zero, w_zero128;
    logic [16:0] r_o_pa;

    assign w_rpd = 21'd1048576 - {1'b0, w_rp21};
    assign w_rpx = {19'd0, w_rpd, 24'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0   <= fx_ssub(fx_rsh(r_fine, 1), FX_64000);              // 11
            r_y2   <= fx_sadd(fx_rsh(w_y6_19, 15), w_x5_19);            // 20
            r_zs   <= fx_sadd(fx_rsh(w_z19, 19), w_p2_19);              // 20
            r_y3   <= fx_sadd(fx_rsh(r_y2, 2), w_p4x);                  // 21
            r_x1   <= fx_rsh(r_zs, 19);                                 // 21
            r_den0 <= fx_sadd(FX_ONE, fx_rsh(r_x1, 15));                // 22
            r_pr0  <= fx_ssub(w_rpx, fx_rsh(r_y3, 12));                 // 22
            r_zero <= (w_den26 == '0);                                  // 27
            r_s1   <= fx_sadd(fx_rsh(w_e9_125, 31), fx_rsh(w_e8_125, 15)); // 126
            r_s2   <= fx_sadd(r_s1, w_p7);                              // 127
            r_pr2  <= fx_sadd(w_pr127, fx_rsh(r_s2, 4));                // 128
            // zero divisor reports the minimum
            r_o_pa <= w_zero128 ? 17'(PA_LO)
                                : 17'(fx_clamp(fx_rsh(r_pr2, 24), PA_LO, PA_HI));
        end
    end

    ecp_fmul u_m_xx  (.i_clk, .i_en(w_en), .i_a(r_x0), .i_b(r_x0),   .o_p(w_xx15));
    ecp_fmul u_m_x5  (.i_clk, .i_en(w_en), .i_a(r_x0), .i_b(w_p5x2), .o_p(w_x5_15));
    ecp_fmul u_m_p3  (.i_clk, .i_en(w_en), .i_a(w_p3), .i_b(r_x0),   .o_p(w_p3_15));
    ecp_fmul u_m_p2  (.i_clk, .i_en(w_en), .i_a(w_p2), .i_b(r_x0),   .o_p(w_p2_15));
    ecp_dly #(.W(64), .N(4)) u_d_x0 (.i_clk, .i_en(w_en), .i_d(r_x0), .o_q(w_x0_15));
    ecp_fmul u_m_y6  (.i_clk, .i_en(w_en), .i_a(w_xx15), .i_b(w_p6), .o_p(w_y6_19));
    ecp_fmul u_m_p3x (.i_clk, .i_en(w_en), .i_a(w_p3_15), .i_b(w_x0_15), .o_p(w_z19));
    ecp_dly #(.W(64), .N(4)) u_d_x5 (.i_clk, .i_en(w_en), .i_d(w_x5_15), .o_q(w_x5_19));
    ecp_dly #(.W(64), .N(4)) u_d_p2 (.i_clk, .i_en(w_en), .i_d(w_p2_15), .o_q(w_p2_19));
    ecp_dly #(.W(20), .N(21)) u_d_rp (.i_clk, .i_en(w_en), .i_d(r_rp), .o_q(w_rp21));
    ecp_fmul u_m_den (.i_clk, .i_en(w_en), .i_a(r_den0), .i_b(w_p1), .o_p(w_den26));
    ecp_fmul u_m_num (.i_clk, .i_en(w_en), .i_a(r_pr0), .i_b(FX_6250), .o_p(w_num26));
    ecp_dly #(.W(1), .N(101)) u_d_zero (.i_clk, .i_en(w_en), .i_d(r_zero),
                                        .o_q(w_zero128));
    ecp_fdiv u_div   (.i_clk, .i_en(w_en), .i_a(w_num26), .i_b(w_den26), .o_q(w_pr117));
    ecp_fmul u_m_e9a (.i_clk, .i_en(w_en), .i_a(w_p9), .i_b(w_pr117), .o_p(w_e9a121));
    ecp_fmul u_m_e8  (.i_clk, .i_en(w_en), .i_a(w_pr117), .i_b(w_p8), .o_p(w_e8_121));
    ecp_dly #(.W(64), .N(4)) u_d_pra (.i_clk, .i_en(w_en), .i_d(w_pr117), .o_q(w_pr121));
    ecp_fmul u_m_e9b (.i_clk, .i_en(w_en), .i_a(w_e9a121), .i_b(w_pr121), .o_p(w_e9_125));
    ecp_dly #(.W(64), .N(4)) u_d_e8 (.i_clk, .i_en(w_en), .i_d(w_e8_121), .o_q(w_e8_125));
    ecp_dly #(.W(64), .N(6)) u_d_prb (.i_clk, .i_en(w_en), .i_d(w_pr121), .o_q(w_pr127));

    // ---------------- humidity ----------------
    t_fx r_dh, r_off, r_c3, r_h6d, r_diff, r_c6, r_k;
    t_fx w_h5_15, w_h3_15, w_h6_15, w_rhx, w_h6c20, w_ds21, w_c3_21;
    t_fx w_cc25, w_ds25, w_h29, w_h1_33, w_h34, w_h2_38;
    logic [15:0] w_rh16;
    logic [16:0] r_hf, w_hf128;

    assign w_rhx = {24'd0, w_rh16, 24'd0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dh   <= fx_ssub(r_fine, FX_76800);                        // 11
            r_off  <= fx_sadd(w_h4x, fx_rsh(w_h5_15, 14));              // 16
            r_c3   <= fx_sadd(FX_ONE, fx_rsh(w_h3_15, 26));             // 16
            r_h6d  <= w_h6_15;                                          // 16
            r_diff <= fx_ssub(w_rhx, r_off);                            // 17
            r_c6   <= fx_sadd(FX_ONE, fx_rsh(w_h6c20, 26));             // 21
            r_k    <= fx_ssub(FX_ONE, fx_rsh(w_h1_33, 19));             // 34
            r_hf   <= 17'(fx_clamp(fx_rsh(w_h2_38, 14), HF_LO, HF_HI)); // 39
        end
    end

    ecp_fmul u_m_h5  (.i_clk, .i_en(w_en), .i_a(w_h5), .i_b(r_dh), .o_p(w_h5_15));
    ecp_fmul u_m_h3  (.i_clk, .i_en(w_en), .i_a(w_h3), .i_b(r_dh), .o_p(w_h3_15));
    ecp_fmul u_m_h6  (.i_clk, .i_en(w_en), .i_a(w_h6), .i_b(r_dh), .o_p(w_h6_15));
    ecp_dly #(.W(16), .N(16)) u_d_rh (.i_clk, .i_en(w_en), .i_d(r_rh), .o_q(w_rh16));
    ecp_fmul u_m_h6c (.i_clk, .i_en(w_en), .i_a(r_h6d), .i_b(r_c3), .o_p(w_h6c20));
    ecp_fmul u_m_ds  (.i_clk, .i_en(w_en), .i_a(r_diff), .i_b(w_slope), .o_p(w_ds21));
    ecp_dly #(.W(64), .N(5)) u_d_c3 (.i_clk, .i_en(w_en), .i_d(r_c3), .o_q(w_c3_21));
    ecp_fmul u_m_cc  (.i_clk, .i_en(w_en), .i_a(w_c3_21), .i_b(r_c6), .o_p(w_cc25));
    ecp_dly #(.W(64), .N(4)) u_d_ds (.i_clk, .i_en(w_en), .i_d(w_ds21), .o_q(w_ds25));
    ecp_fmul u_m_h   (.i_clk, .i_en(w_en), .i_a(w_ds25), .i_b(w_cc25), .o_p(w_h29));
    ecp_fmul u_m_h1  (.i_clk, .i_en(w_en), .i_a(w_h1), .i_b(w_h29), .o_p(w_h1_33));
    ecp_dly #(.W(64), .N(5)) u_d_h (.i_clk, .i_en(w_en), .i_d(w_h29), .o_q(w_h34));
    ecp_fmul u_m_h2  (.i_clk, .i_en(w_en), .i_a(w_h34), .i_b(r_k), .o_p(w_h2_38));
    ecp_dly #(.W(17), .N(89)) u_d_hf (.i_clk, .i_en(w_en), .i_d(r_hf), .o_q(w_hf128));

    // ---------------- output register ----------------
    logic [14:0] r_o_tc;
    logic [16:0] r_o_hf;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_tc <= w_tc128;
            r_o_hf <= w_hf128;
        end
    end

    assign m_axis_tdata = {7'd0, r_o_hf, r_o_pa, r_o_tc};

endmodule

@@ rtl/ecp_chk.sv @@
module ecp_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // never refuse a request while the output register is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request refused with empty output");

    a_temp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $signed(m_axis_tdata[14:0]) >= -4000
                       && $signed(m_axis_tdata[14:0]) <= 8500)
        else $error("temperature out of range");

    a_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[31:15] >= 17'd30000
                       && m_axis_tdata[31:15] <= 17'd110000)
        else $error("pressure out of range");

    a_hum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[48:32] <= 17'd102400 && m_axis_tdata[55:49] == 7'd0)
        else $error("humidity out of range");

endmodule

bind env_sensor_compensation ecp_chk u_ecp_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ verif/env_sensor_compensation_test.sv @@
`timescale 1ns / 1ps

module env_sensor_compensation_test;
    import ecp_pkg::*;

    localparam int  RUN_LIMIT   = 400000;
    localparam int  DRAIN_WAIT  = 140;   // longer than the pipeline
    localparam logic [2:0] IDX_UNMAPPED    = 3'd5;
    localparam logic [2:0] IDX_UNMAPPED_HI = 3'd7;
    localparam longint S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint S64_MIN = 64'sh8000_0000_0000_0000;
    localparam longint Q_ONE   = 64'sd1 <<< 24;

    typedef struct packed {
        logic [15:0] rh;
        logic [19:0] rp;
        logic [19:0] rt;
    } t_reading;

    typedef struct packed {
        logic [16:0] hf;
        logic [16:0] pa;
        logic [14:0] tc;
    } t_compensated;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_idx = '0;
    logic [63:0] i_cfg_wdata = '0;

    // calibration image as the block should hold it
    logic [63:0]  cal_image [5];
    t_reading     pending_readings [$];
    t_compensated expected_results [$];
    logic         request_taken = 1'b0;
    logic         hold_sender = 1'b0;
    int           cycle_count = 0;
    int           error_count = 0;

    env_sensor_compensation DUT (.*);

    always #5 i_clk = ~i_clk;

    // ---------------- fixed-point predictor ----------------
    function automatic logic [63:0] mag_of(longint a);
        return a < 0 ? 64'd0 - 64'(a) : 64'(a);
    endfunction

    function automatic longint apply_sign(bit neg, logic [63:0] m);
        if (!neg) return m[63] ? S64_MAX : longint'(m);
        if (m[63]) return S64_MIN;
        return -longint'(m);
    endfunction

    function automatic longint q_add(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint q_sub(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) - 65'(b);
        if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
        return longint'(s[63:0]);
    endfunction

    function automatic longint q_int(longint k);
        return k * Q_ONE;
    endfunction

    // divide by 2^n, round half away from zero
    function automatic longint q_shr(longint a, int n);
        logic [63:0] m;
        m = mag_of(a);
        return apply_sign(a < 0, (m >> n) + ((m >> (n - 1)) & 64'd1));
    endfunction

    function automatic longint q_mul(longint a, longint b);
        logic [127:0] p;
        p = {64'd0, mag_of(a)} * {64'd0, mag_of(b)};
        p = (p + (128'd1 << 23)) >> 24;
        return apply_sign((a < 0) != (b < 0), p[127:64] != 0 ? '1 : p[63:0]);
    endfunction

    function automatic longint q_div(longint a, longint b);
        logic [127:0] num, den, quo, rem;
        num = {64'd0, mag_of(a)} << 24;
        den = {64'd0, mag_of(b)};
        quo = num / den;
        rem = num % den;
        if (rem >= den - rem) quo = quo + 1;
        return apply_sign((a < 0) != (b < 0), quo[127:64] != 0 ? '1 : quo[63:0]);
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic t_compensated compensate_reading(t_reading rd);
        longint t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
        longint h1, h2, h3, h4, h5, h6;
        longint raw, lin, sq, fine, tc, pa, hf, x, y, z, den, pr, e9, e8;
        longint dh, off, diff, slope, c3, c6, h;
        t_compensated res;
        t1 = longint'(cal_image[REG_CAL_TEMP][15:0]);
        t2 = longint'($signed(cal_image[REG_CAL_TEMP][31:16]));
        t3 = longint'($signed(cal_image[REG_CAL_TEMP][47:32]));
        p1 = longint'(cal_image[REG_CAL_PRESS_LOW][15:0]);
        p2 = longint'($signed(cal_image[REG_CAL_PRESS_LOW][31:16]));
        p3 = longint'($signed(cal_image[REG_CAL_PRESS_LOW][47:32]));
        p4 = longint'($signed(cal_image[REG_CAL_PRESS_LOW][63:48]));
        p5 = longint'($signed(cal_image[REG_CAL_PRESS_HIGH][15:0]));
        p6 = longint'($signed(cal_image[REG_CAL_PRESS_HIGH][31:16]));
        p7 = longint'($signed(cal_image[REG_CAL_PRESS_HIGH][47:32]));
        p8 = longint'($signed(cal_image[REG_CAL_PRESS_HIGH][63:48]));
        p9 = longint'($signed(cal_image[REG_CAL_PRESS9_HUM][15:0]));
        h1 = longint'(cal_image[REG_CAL_PRESS9_HUM][23:16]);
        h2 = longint'($signed(cal_image[REG_CAL_PRESS9_HUM][39:24]));
        h3 = longint'(cal_image[REG_CAL_PRESS9_HUM][47:40]);
        h4 = longint'(cal_image[REG_CAL_HUM_SHAPE][11:0]);
        h5 = longint'(cal_image[REG_CAL_HUM_SHAPE][23:12]);
        h6 = longint'($signed(cal_image[REG_CAL_HUM_SHAPE][31:24]));

        // fine temperature feeds all three outputs
        raw  = q_int(longint'(rd.rt));
        lin  = q_mul(q_sub(q_shr(raw, 14), q_shr(q_int(t1), 10)), q_int(t2));
        sq   = q_sub(q_shr(raw, 17), q_shr(q_int(t1), 13));
        sq   = q_mul(q_mul(sq, sq), q_int(t3));
        fine = q_add(lin, sq);
        tc   = clip(q_shr(q_mul(fine, q_int(5)), 32), -4000, 8500);

        x   = q_sub(q_shr(fine, 1), q_int(64000));
        y   = q_shr(q_mul(q_mul(x, x), q_int(p6)), 15);
        y   = q_add(y, q_mul(x, q_int(p5 * 2)));
        y   = q_add(q_shr(y, 2), q_int(p4 * 65536));
        z   = q_shr(q_mul(q_mul(q_int(p3), x), x), 19);
        x   = q_shr(q_add(z, q_mul(q_int(p2), x)), 19);
        den = q_mul(q_add(Q_ONE, q_shr(x, 15)), q_int(p1));
        if (den == 0) begin
            pa = 30000;  // zero divisor reports the floor
        end else begin
            pr = q_sub(q_int(1048576 - longint'(rd.rp)), q_shr(y, 12));
            pr = q_div(q_mul(pr, q_int(6250)), den);
            e9 = q_shr(q_mul(q_mul(q_int(p9), pr), pr), 31);
            e8 = q_shr(q_mul(pr, q_int(p8)), 15);
            pr = q_add(pr, q_shr(q_add(q_add(e9, e8), q_int(p7)), 4));
            pa = clip(q_shr(pr, 24), 30000, 110000);
        end

        dh    = q_sub(fine, q_int(76800));
        off   = q_add(q_int(h4 * 64), q_shr(q_mul(q_int(h5), dh), 14));
        diff  = q_sub(q_int(longint'(rd.rh)), off);
        slope = q_shr(q_int(h2), 16);
        c3    = q_add(Q_ONE, q_shr(q_mul(q_int(h3), dh), 26));
        c6    = q_add(Q_ONE, q_shr(q_mul(q_mul(q_int(h6), dh), c3), 26));
        h     = q_mul(q_mul(diff, slope), q_mul(c3, c6));
        h     = q_mul(h, q_sub(Q_ONE, q_shr(q_mul(q_int(h1), h), 19)));
        hf    = clip(q_shr(h, 14), 0, 102400);

        res.tc = tc[14:0];
        res.pa = pa[16:0];
        res.hf = hf[16:0];
        return res;
    endfunction

    // ---------------- random idling ----------------
    // no idling at all during a quiet window early in the random part
    function automatic bit idle_now();
        if (cycle_count >= 3000 && cycle_count < 6000) return 1'b0;
        return $urandom_range(99) < 15;
    endfunction

    // ---------------- driver ----------------
    always @(posedge i_clk) request_taken <= s_axis_tvalid && s_axis_tready;

    always @(negedge i_clk) begin
        m_axis_tready <= !idle_now();
        if (!s_axis_tvalid || request_taken) begin
            if (pending_readings.size() > 0 && !hold_sender && i_rst_n && !idle_now()) begin
                s_axis_tdata  <= pending_readings.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge i_clk) begin
        t_compensated want, got;
        cycle_count <= cycle_count + 1;
        if (s_axis_tvalid && s_axis_tready)
            expected_results.push_back(compensate_reading(t_reading'(s_axis_tdata)));
        if (m_axis_tvalid && m_axis_tready) begin
            got = t_compensated'(m_axis_tdata[48:0]);
            if (expected_results.size() == 0) begin
                $error("unexpected result %h", m_axis_tdata);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (got.tc !== want.tc) begin
                    $error("temperature_centi expected %0d got %0d",
                           $signed(want.tc), $signed(got.tc));
                    error_count++;
                end
                if (got.pa !== want.pa) begin
                    $error("pressure_pa expected %0d got %0d", want.pa, got.pa);
                    error_count++;
                end
                if (got.hf !== want.hf) begin
                    $error("humidity_frac expected %0d got %0d", want.hf, got.hf);
                    error_count++;
                end
                if (m_axis_tdata[55:49] !== '0) begin
                    $error("pad bits expected 0 got %h", m_axis_tdata[55:49]);
                    error_count++;
                end
            end
        end
        if (cycle_count > RUN_LIMIT) begin
            $display("env_sensor_compensation_test NOT OK");
            $finish;
        end
    end

    // ---------------- sequencing ----------------
    task automatic wait_drained();
        while (pending_readings.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // write a register; track the masked value for unmapped bits
    task automatic write_cal(logic [2:0] idx, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        case (idx)
            REG_CAL_TEMP, REG_CAL_PRESS9_HUM: cal_image[idx] = {16'd0, value[47:0]};
            REG_CAL_PRESS_LOW, REG_CAL_PRESS_HIGH: cal_image[idx] = value;
            REG_CAL_HUM_SHAPE: cal_image[idx] = {32'd0, value[31:0]};
            default: ;  // unmapped index: drop
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic load_all(logic [63:0] ct, logic [63:0] pl, logic [63:0] ph,
                            logic [63:0] p9h, logic [63:0] hs);
        write_cal(REG_CAL_TEMP, ct);
        write_cal(REG_CAL_PRESS_LOW, pl);
        write_cal(REG_CAL_PRESS_HIGH, ph);
        write_cal(REG_CAL_PRESS9_HUM, p9h);
        write_cal(REG_CAL_HUM_SHAPE, hs);
    endtask

    // typical part calibration, optionally jittered
    task automatic load_typical(bit jitter);
        logic [15:0] t1, t2, t3, p[10];
        logic [7:0]  h1, h3, h6;
        logic [15:0] h2;
        logic [11:0] h4, h5;
        t1 = 16'd27504; t2 = 16'd26435; t3 = -16'sd1000;
        p[1] = 16'd36477; p[2] = -16'sd10685; p[3] = 16'd3024; p[4] = 16'd2855;
        p[5] = 16'd140; p[6] = -16'sd7; p[7] = 16'd15500; p[8] = -16'sd14600;
        p[9] = 16'd6000;
        h1 = 8'd75; h2 = 16'd362; h3 = 8'd0; h4 = 12'd313; h5 = 12'd50; h6 = 8'd30;
        if (jitter) begin
            t1 = t1 + 16'($urandom_range(2000)) - 16'd1000;
            t2 = t2 + 16'($urandom_range(2000)) - 16'd1000;
            t3 = 16'($urandom_range(4000)) - 16'd2000;
            for (int k = 1; k <= 9; k++) p[k] = p[k] + 16'($urandom_range(400)) - 16'd200;
            h1 = 8'($urandom); h2 = 16'($urandom_range(800)); h3 = 8'($urandom);
            h4 = 12'($urandom); h5 = 12'($urandom); h6 = 8'($urandom);
        end
        load_all({16'($urandom), t3, t2, t1}, {p[4], p[3], p[2], p[1]},
                 {p[8], p[7], p[6], p[5]}, {16'($urandom), h3, h2, h1, p[9]},
                 {32'($urandom), h6, h5, h4});
    endtask

    function automatic t_reading any_reading();
        t_reading rd;
        rd.rt = 20'($urandom);
        rd.rp = 20'($urandom);
        rd.rh = 16'($urandom);
        return rd;
    endfunction

    // mostly readings a real part produces, with some full-range noise
    function automatic t_reading plausible_reading();
        t_reading rd;
        if ($urandom_range(99) < 20) return any_reading();
        rd.rt = 20'($urandom_range(600000, 400000));
        rd.rp = 20'($urandom_range(550000, 200000));
        rd.rh = 16'($urandom_range(45000, 15000));
        return rd;
    endfunction

    task automatic queue_random(int count);
        for (int k = 0; k < count; k++) pending_readings.push_back(plausible_reading());
    endtask

    initial begin
        foreach (cal_image[k]) cal_image[k] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset calibration: zero divisor everywhere
        pending_readings.push_back('{16'hFFFF, 20'hFFFFF, 20'hFFFFF});
        pending_readings.push_back('{16'h0, 20'h0, 20'h0});
        wait_drained();

        // typical calibration across the field extremes
        load_typical(1'b0);
        write_cal(IDX_UNMAPPED, '1);
        write_cal(IDX_UNMAPPED_HI, 64'h0123_4567_89AB_CDEF);
        pending_readings.push_back('{16'd0, 20'd0, 20'd0});
        pending_readings.push_back('{16'hFFFF, 20'hFFFFF, 20'hFFFFF});
        pending_readings.push_back('{16'hFFFF, 20'd0, 20'd519888});
        pending_readings.push_back('{16'd0, 20'hFFFFF, 20'd519888});
        pending_readings.push_back('{16'd30000, 20'd415148, 20'd519888});
        pending_readings.push_back('{16'd30000, 20'd415148, 20'd0});
        pending_readings.push_back('{16'd30000, 20'd415148, 20'hFFFFF});
        pending_readings.push_back('{16'hAAAA, 20'h55555, 20'hAAAAA});
        pending_readings.push_back('{16'h5555, 20'hAAAAA, 20'h55555});
        pending_readings.push_back('{16'd65000, 20'd300000, 20'd430000});
        wait_drained();

        // every calibration bit set
        load_all('1, '1, '1, '1, '1);
        pending_readings.push_back('{16'hFFFF, 20'hFFFFF, 20'hFFFFF});
        pending_readings.push_back('{16'd0, 20'd0, 20'd0});
        pending_readings.push_back('{16'd30000, 20'd415148, 20'd519888});
        wait_drained();

        // signed coefficients at their positive and negative extremes
        load_all(64'h7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                 64'hFF_7FFF_FF_7FFF, 64'h7F_FFF_FFF);
        pending_readings.push_back('{16'hFFFF, 20'hFFFFF, 20'hFFFFF});
        pending_readings.push_back('{16'd0, 20'd0, 20'd0});
        wait_drained();
        load_all(64'h8000_8000_0001, 64'h8000_8000_8000_0001, 64'h8000_8000_8000_8000,
                 64'h00_8000_00_8000, 64'h80_000_001);
        pending_readings.push_back('{16'hFFFF, 20'hFFFFF, 20'hFFFFF});
        pending_readings.push_back('{16'd0, 20'd0, 20'd0});
        wait_drained();

        // random part: typical calibrations, jittered ones, fully random ones
        for (int ph = 0; ph < 6; ph++) begin
            case (ph % 3)
                0: load_typical(1'b0);
                1: load_typical(1'b1);
                default: load_all({$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom}, {$urandom, $urandom},
                                  {$urandom, $urandom});
            endcase
            queue_random(145);
            // hold the sender once until the pipeline has emptied
            if (ph == 2) begin
                while (pending_readings.size() > 100) @(posedge i_clk);
                hold_sender = 1'b1;
                while (expected_results.size() > 0 || s_axis_tvalid) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            queue_random(145);
            wait_drained();
        end

        if (error_count == 0) begin
            $display("env_sensor_compensation_test OK");
        end else begin
            $display("env_sensor_compensation_test NOT OK");
        end
        $finish;
    end

endmodule
